FILE: rtl/core/indented_tree_longest_path_parser_core_macros.svh
// Assertion macros of the indented tree parser RTL, used by the level stack.
`ifndef INDENTED_TREE_LONGEST_PATH_PARSER_CORE_MACROS_SVH
`define INDENTED_TREE_LONGEST_PATH_PARSER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, quiet during reset
`define ITLPP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, quiet during reset
`define ITLPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/itlpp_pkg.sv
// Package: shared constants and types of the indented tree parser.
`default_nettype none
package itlpp_pkg;

  localparam int STACK_DEPTH_DEF = 64;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int OUT_BITS        = 16;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_DOT     = 8'd46;

  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  typedef struct packed {
    logic valid;
    logic push;
    logic is_file;
    logic last;
    logic ovf;
  } itlpp_evt_t;

endpackage
`default_nettype wire

FILE: rtl/core/itlpp_if.sv
// Interfaces: input byte channel and result channel.
`default_nettype none
interface itlpp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface itlpp_out_if;
  logic                          valid;
  logic                          ready;
  logic [itlpp_pkg::OUT_BITS-1:0] longest_length;
  logic                          overflow;

  modport source (output valid, output longest_length, output overflow, input ready);
  modport sink (input valid, input longest_length, input overflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/indented_tree_longest_path_parser_core.sv
// Top level: longest file path over an indented tree listing.
// One byte is taken every cycle while the result register is free or being drained.
// The result of a listing passes the level-stack stage, where the memory is read and
// the length updated, and then the output register. The stack memory's
// read-modify-write loop, with write-to-read forwarding, sets the one-byte-per-cycle
// rate; no clearing pass is needed after reset.
`default_nettype none
module indented_tree_longest_path_parser_core #(
  parameter int STACK_DEPTH = itlpp_pkg::STACK_DEPTH_DEF,
  parameter int LENGTH_BITS = itlpp_pkg::LENGTH_BITS_DEF
) (
  input wire           clk,
  input wire           rst_n,
  itlpp_in_if.sink     in_ch,
  itlpp_out_if.source  out_ch
);

  localparam int AW = $clog2(STACK_DEPTH);

  itlpp_pkg::itlpp_evt_t              evt;
  logic [LENGTH_BITS-1:0]             evt_name;
  logic [AW-1:0]                      rd_addr, wr_addr;
  logic                               adv, accept, res_valid, res_ovf;
  logic [itlpp_pkg::OUT_BITS-1:0]     res_len;

  logic                               out_valid_r, out_ovf_r;
  logic [itlpp_pkg::OUT_BITS-1:0]     out_len_r;

  assign adv          = !out_valid_r || out_ch.ready;
  assign accept       = in_ch.valid && adv;
  assign in_ch.ready  = adv;

  itlpp_scan #(
    .STACK_DEPTH (STACK_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .text_byte  (in_ch.text_byte),
    .final_byte (in_ch.final_byte),
    .evt        (evt),
    .evt_name   (evt_name),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr)
  );

  itlpp_stack #(
    .STACK_DEPTH (STACK_DEPTH),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .evt       (evt),
    .evt_name  (evt_name),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .res_valid (res_valid),
    .res_len   (res_len),
    .res_ovf   (res_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_len_r <= res_len;
      out_ovf_r <= res_ovf;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.longest_length = out_len_r;
  assign out_ch.overflow       = out_ovf_r;

endmodule
`default_nettype wire

FILE: rtl/core/itlpp_scan.sv
// Line scanner: tracks indent, name length and level count; issues stack events.
`default_nettype none
module itlpp_scan #(
  parameter int STACK_DEPTH = itlpp_pkg::STACK_DEPTH_DEF,
  parameter int LENGTH_BITS = itlpp_pkg::LENGTH_BITS_DEF,
  localparam int IW = $clog2(STACK_DEPTH + 2),
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          accept,
  input  wire  [7:0]                   text_byte,
  input  wire                          final_byte,
  output itlpp_pkg::itlpp_evt_t        evt,
  output logic [LENGTH_BITS-1:0]       evt_name,
  output logic [AW-1:0]                rd_addr,
  output logic [AW-1:0]                wr_addr
);

  localparam logic [IW-1:0] DEPTH_W = IW'(STACK_DEPTH);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  logic [IW-1:0]          indent_r, indent_nxt, lvl_r, lvl_nxt;
  logic [LENGTH_BITS-1:0] name_r, name_nxt;
  logic                   at_start_r, at_start_nxt, dot_r, dot_nxt, ovf_r, ovf_nxt;

  logic                   is_nl, is_tab, is_char, line_end, name_sat, full;
  logic [IW-1:0]          indent_p, indent_inc, lc;
  logic [LENGTH_BITS-1:0] name_p;
  logic                   dot_p, ovf_p;

  always_comb begin
    is_nl      = text_byte == itlpp_pkg::CH_NEWLINE;
    is_tab     = !is_nl && text_byte == itlpp_pkg::CH_TAB && at_start_r;
    is_char    = !is_nl && !is_tab;
    indent_p   = (is_tab && indent_r < DEPTH_W) ? indent_r + 1'b1 : indent_r;
    name_sat   = is_char && name_r == LEN_MAX;
    name_p     = (is_char && !name_sat) ? name_r + 1'b1 : name_r;
    dot_p      = dot_r | (is_char && text_byte == itlpp_pkg::CH_DOT);
    ovf_p      = ovf_r | name_sat;
    line_end   = is_nl || final_byte;
    indent_inc = indent_p + 1'b1;
    lc         = (indent_inc < lvl_r) ? indent_inc : lvl_r;
    full       = !dot_p && lc >= DEPTH_W;

    evt.valid   = accept && line_end;
    evt.push    = !dot_p && !full;
    evt.is_file = dot_p;
    evt.last    = final_byte;
    evt.ovf     = ovf_p | full;
    evt_name    = name_p;
    rd_addr     = AW'(lc - 1'b1);
    wr_addr     = AW'(lc);

    indent_nxt   = indent_p;
    name_nxt     = name_p;
    at_start_nxt = at_start_r && !is_char;
    dot_nxt      = dot_p;
    ovf_nxt      = ovf_p | (line_end && full);
    lvl_nxt      = lvl_r;
    if (line_end) begin
      indent_nxt   = '0;
      name_nxt     = '0;
      at_start_nxt = 1'b1;
      dot_nxt      = 1'b0;
      lvl_nxt      = (!dot_p && !full) ? lc + 1'b1 : lc;
    end
    if (final_byte) begin
      ovf_nxt = 1'b0;
      lvl_nxt = IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      indent_r   <= '0;
      name_r     <= '0;
      at_start_r <= 1'b1;
      dot_r      <= 1'b0;
      ovf_r      <= 1'b0;
      lvl_r      <= IW'(1);
    end else if (accept) begin
      indent_r   <= indent_nxt;
      name_r     <= name_nxt;
      at_start_r <= at_start_nxt;
      dot_r      <= dot_nxt;
      ovf_r      <= ovf_nxt;
      lvl_r      <= lvl_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/itlpp_stack.sv
// Level stack: length memory with read-modify-write, forwarding and best tracking.
`default_nettype none
`include "indented_tree_longest_path_parser_core_macros.svh"
module itlpp_stack #(
  parameter int STACK_DEPTH = itlpp_pkg::STACK_DEPTH_DEF,
  parameter int LENGTH_BITS = itlpp_pkg::LENGTH_BITS_DEF,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                adv,
  input  wire  itlpp_pkg::itlpp_evt_t        evt,
  input  wire  [LENGTH_BITS-1:0]             evt_name,
  input  wire  [AW-1:0]                      rd_addr,
  input  wire  [AW-1:0]                      wr_addr,
  output logic                               res_valid,
  output logic [itlpp_pkg::OUT_BITS-1:0]     res_len,
  output logic                               res_ovf
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
  localparam logic [LENGTH_BITS-1:0] OUT_LIM = LENGTH_BITS'(itlpp_pkg::OUT_MAX);

  logic [LENGTH_BITS-1:0] mem [STACK_DEPTH];

  itlpp_pkg::itlpp_evt_t  ev_r;
  logic [LENGTH_BITS-1:0] name_r, rdata_r, fwd_data_r, best_r, best_nxt;
  logic [AW-1:0]          wr_addr_r, rd_addr_r;
  logic                   fwd_r, ovf_r, ovf_nxt;

  logic [LENGTH_BITS-1:0] parent, val;
  logic [LENGTH_BITS:0]   sum;
  logic                   sat, do_push, big;

  always_comb begin
    if (rd_addr_r == '0) begin
      parent = '0;
    end else if (fwd_r) begin
      parent = fwd_data_r;
    end else begin
      parent = rdata_r;
    end
    sum      = {1'b0, parent} + {1'b0, name_r} + (LENGTH_BITS+1)'(ev_r.push);
    sat      = sum[LENGTH_BITS];
    val      = sat ? LEN_MAX : sum[LENGTH_BITS-1:0];
    do_push  = ev_r.valid && ev_r.push;
    best_nxt = (ev_r.is_file && val > best_r) ? val : best_r;
    ovf_nxt  = ovf_r | ev_r.ovf | sat;
    big      = best_nxt > OUT_LIM;
    res_valid = ev_r.valid && ev_r.last;
    res_len   = big ? itlpp_pkg::OUT_MAX : itlpp_pkg::OUT_BITS'(best_nxt);
    res_ovf   = ovf_nxt | big;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rdata_r <= mem[rd_addr];
      if (do_push) begin
        mem[wr_addr_r] <= val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      name_r     <= evt_name;
      wr_addr_r  <= wr_addr;
      rd_addr_r  <= rd_addr;
      fwd_data_r <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r   <= '0;
      fwd_r  <= 1'b0;
      best_r <= '0;
      ovf_r  <= 1'b0;
    end else if (adv) begin
      ev_r  <= evt;
      fwd_r <= do_push && wr_addr_r == rd_addr;
      if (ev_r.valid) begin
        best_r <= ev_r.last ? '0 : best_nxt;
        ovf_r  <= ev_r.last ? 1'b0 : ovf_nxt;
      end
    end
  end

  `ITLPP_ASSERT_NOW(a_push_not_root, ev_r.valid && ev_r.push, wr_addr_r != '0, "push to root")
  `ITLPP_ASSERT_NOW(a_fwd_not_root, ev_r.valid && fwd_r, rd_addr_r != '0, "forward on root")
  `ITLPP_ASSERT_NEXT(a_best_cleared, adv && ev_r.valid && ev_r.last, best_r == '0 && !ovf_r,
    "best not cleared after last beat")

endmodule
`default_nettype wire

FILE: sim/indented_tree_longest_path_parser_core_tb.sv
// Testbench: byte-stream regression of the indented tree longest path parser core.
`default_nettype none
module indented_tree_longest_path_parser_core_tb;

  localparam int STACK = itlpp_pkg::STACK_DEPTH_DEF;
  localparam int LEN_MAX = (1 << itlpp_pkg::LENGTH_BITS_DEF) - 1;
  localparam int OUT_W = itlpp_pkg::OUT_BITS;
  localparam int HOLD_OFF = 400;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE = 4;
  localparam int RANDOM_BYTES = 1100;
  localparam int RANDOM_LISTINGS_MIN = 20;
  localparam logic [7:0] CH_A = 8'd97;
  localparam logic [7:0] CH_Z = 8'd122;

  typedef logic [itlpp_pkg::LENGTH_BITS_DEF-1:0] len_t;
  typedef logic [7:0] listing_t[$];
  typedef struct packed {
    logic [OUT_W-1:0] longest;
    logic             ovf;
  } path_result_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

  logic clk;
  logic rst_n;

  itlpp_in_if  in_ch ();
  itlpp_out_if out_ch ();

  indented_tree_longest_path_parser_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  len_t level_len[STACK];
  int   open_levels;
  int   indent_tabs;
  len_t pend_len;
  bit   line_fresh;
  bit   name_dot;
  len_t best_len;
  bit   len_sat;

  path_result_t expected_paths[$];
  int errors;
  int idle_cycles;
  int burst_left;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_tree();
    level_len[0] = '0;
    open_levels = 1;
    indent_tabs = 0;
    pend_len = '0;
    line_fresh = 1'b1;
    name_dot = 1'b0;
    best_len = '0;
    len_sat = 1'b0;
  endfunction

  function automatic len_t clamp_len(input int v);
    if (v > LEN_MAX) begin
      len_sat = 1'b1;
      return len_t'(LEN_MAX);
    end
    return len_t'(v);
  endfunction

  function automatic void close_line();
    len_t parent;
    len_t total;
    if (indent_tabs + 1 < open_levels) open_levels = indent_tabs + 1;
    if (open_levels > STACK) open_levels = STACK;
    parent = level_len[open_levels-1];
    if (name_dot) begin
      total = clamp_len(int'(parent) + int'(pend_len));
      if (total > best_len) best_len = total;
    end else if (open_levels >= STACK) begin
      len_sat = 1'b1;
    end else begin
      level_len[open_levels] = clamp_len(int'(parent) + int'(pend_len) + 1);
      open_levels++;
    end
    indent_tabs = 0;
    pend_len = '0;
    line_fresh = 1'b1;
    name_dot = 1'b0;
  endfunction

  function automatic void take_byte(input logic [7:0] b, input logic last);
    path_result_t r;
    if (b == itlpp_pkg::CH_NEWLINE) begin
      close_line();
    end else if (b == itlpp_pkg::CH_TAB && line_fresh) begin
      if (indent_tabs < STACK) indent_tabs++;
    end else begin
      line_fresh = 1'b0;
      pend_len = clamp_len(int'(pend_len) + 1);
      if (b == itlpp_pkg::CH_DOT) name_dot = 1'b1;
    end
    if (last) begin
      if (b != itlpp_pkg::CH_NEWLINE) close_line();
      if (int'(best_len) > int'(itlpp_pkg::OUT_MAX)) begin
        r.longest = itlpp_pkg::OUT_MAX;
        r.ovf = 1'b1;
      end else begin
        r.longest = OUT_W'(best_len);
        r.ovf = len_sat;
      end
      expected_paths.push_back(r);
      clear_tree();
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  always @(posedge clk) begin : monitor
    bit moved;
    path_result_t want;
    moved = 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      take_byte(in_ch.text_byte, in_ch.final_byte);
      moved = 1'b1;
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      moved = 1'b1;
      if (expected_paths.size() == 0) begin
        report_mismatch("unexpected result, longest_length", out_ch.longest_length, 0);
      end else begin
        want = expected_paths.pop_front();
        if (out_ch.longest_length !== want.longest)
          report_mismatch("longest_length", out_ch.longest_length, want.longest);
        if (out_ch.overflow !== want.ovf)
          report_mismatch("overflow", out_ch.overflow, want.ovf);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("indented_tree_longest_path_parser_core regression: fail");
      $finish;
    end
  end

  initial begin : receiver
    rx_mode_t mode;
    int span;
    out_ch.ready <= 1'b0;
    mode = RX_OPEN;
    span = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        hold_req = 1'b0;
      end
      if (span == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        span = $urandom_range(32, 256);
      end
      span--;
      case (mode)
        RX_OPEN: begin
          out_ch.ready <= 1'b1;
        end
        RX_COIN: begin
          out_ch.ready <= 1'($urandom_range(0, 1));
        end
        RX_SPARSE: begin
          out_ch.ready <= ($urandom_range(0, 4) == 0);
        end
        default: begin
          out_ch.ready <= (span % 3 != 0);
        end
      endcase
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.final_byte <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_listing(input listing_t txt);
    foreach (txt[i]) send_byte(txt[i], i == txt.size() - 1);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_paths.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic listing_t from_text(input string s);
    listing_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    return t;
  endfunction

  function automatic logic [7:0] name_char();
    logic [7:0] c;
    if ($urandom_range(0, 7) != 0) return 8'($urandom_range(CH_A, CH_Z));
    do c = 8'($urandom_range(0, 255)); while (c == itlpp_pkg::CH_NEWLINE);
    return c;
  endfunction

  function automatic listing_t random_listing();
    listing_t txt;
    int lines;
    int depth;
    int open_depth;
    int nlen;
    bit is_file;
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 16)) txt.push_back(8'($urandom_range(0, 255)));
      return txt;
    end
    lines = $urandom_range(1, 8);
    open_depth = 0;
    repeat (lines) begin
      depth = ($urandom_range(0, 9) == 0) ? open_depth + $urandom_range(2, 4)
                                           : $urandom_range(0, open_depth);
      repeat (depth) txt.push_back(itlpp_pkg::CH_TAB);
      nlen = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      is_file = ($urandom_range(0, 2) == 0);
      repeat (nlen) txt.push_back(name_char());
      if (is_file) begin
        txt.push_back(itlpp_pkg::CH_DOT);
        repeat ($urandom_range(0, 3)) txt.push_back(name_char());
      end
      txt.push_back(itlpp_pkg::CH_NEWLINE);
      if (!is_file) open_depth = depth + 1;
    end
    if ($urandom_range(0, 1) == 1) void'(txt.pop_back());
    if (txt.size() == 0) txt.push_back(itlpp_pkg::CH_DOT);
    return txt;
  endfunction

  task automatic test_single_bytes();
    listing_t t;
    send_listing(from_text("."));
    send_listing(from_text("x"));
    send_listing(from_text("\n"));
    send_listing(from_text("\t"));
    send_listing(from_text(".\n"));
    t = {8'h00};
    send_listing(t);
    t = {8'hFF, itlpp_pkg::CH_DOT, 8'hFF};
    send_listing(t);
    wait_drained();
  endtask

  task automatic test_small_trees();
    send_listing(from_text("dir\n\tsubdir1\n\tsubdir2\n\t\tfile.ext\n"));
    send_listing(from_text("dir\n\tsub1\n\t\tf1.a\n\tsub2\n\t\tss\n\t\t\tlonger.ext"));
    send_listing(from_text("a\tb.c\nab\t\n\tx.y"));
    send_listing(from_text("\n\n\tx.y\n"));
    send_listing(from_text("a\n\t\t\tb.c\n"));
    send_listing(from_text("plain\n\tdirs\n\t\tonly\n"));
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (12) send_listing(from_text("ab\n\tc.d"));
    wait_drained();
  endtask

  task automatic test_random_listings();
    listing_t txt;
    int bytes;
    int lists;
    bytes = 0;
    lists = 0;
    while (bytes < RANDOM_BYTES || lists < RANDOM_LISTINGS_MIN) begin
      txt = random_listing();
      send_listing(txt);
      bytes += txt.size();
      lists++;
      if ($urandom_range(0, 15) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    burst_left = 0;
    hold_req = 1'b0;
    clear_tree();
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.text_byte <= '0;
    in_ch.final_byte <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_single_bytes();
    test_small_trees();
    test_backpressure();
    test_random_listings();
    wait_drained();
    if (errors == 0) begin
      $display("indented_tree_longest_path_parser_core regression: pass");
    end else begin
      $display("indented_tree_longest_path_parser_core regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: indented_tree_longest_path_parser_core.f
+incdir+rtl/core
rtl/core/itlpp_pkg.sv
rtl/core/itlpp_if.sv
rtl/core/itlpp_scan.sv
rtl/core/itlpp_stack.sv
rtl/core/indented_tree_longest_path_parser_core.sv
sim/indented_tree_longest_path_parser_core_tb.sv
